/* src/scp_pkg.sv */
// Shared types, constants and arithmetic helpers of the sine/cosine polynomial block.
package scp_pkg;

  localparam int ANGLE_W = 24;
  localparam int OUT_W   = 18;
  localparam int Q_W     = 13;
  localparam int T_W     = 32;
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // 2/pi as unsigned Q0.32, and pi/2 in units of 2^-40 (Q30 high part times 1024 plus low part).
  localparam logic signed [56:0] TWO_OVER_PI_Q32 = 57'sd2734261102;
  localparam logic signed [57:0] PIO2_Q40        = 58'sd1727108826179;

  localparam logic signed [T_W-1:0] SIN_K3 = -32'sd209210;
  localparam logic signed [T_W-1:0] SIN_K2 = 32'sd8946198;
  localparam logic signed [T_W-1:0] SIN_K1 = -32'sd178956710;
  localparam logic signed [T_W-1:0] SIN_K0 = 32'sd1073741813;
  localparam logic signed [T_W-1:0] COS_K3 = -32'sd1460921;
  localparam logic signed [T_W-1:0] COS_K2 = 32'sd44728461;
  localparam logic signed [T_W-1:0] COS_K1 = -32'sd536869705;
  localparam logic signed [T_W-1:0] COS_K0 = 32'sd1073741803;

  // Reduced angle handed from the front end to the evaluator.
  typedef struct packed {
    logic signed [T_W-1:0] t;
    logic [1:0]            quad;
  } scp_red_t;

  // Front end status towards the queue.
  typedef struct packed {
    logic       push;
    logic [1:0] busy;
  } scp_fstat_t;

  // Queue status towards the front end.
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } scp_qstat_t;

  // Q30 by Q30 product, rounded half up back to Q30.
  function automatic logic signed [T_W-1:0] mul_q30(input logic signed [T_W-1:0] a,
                                                     input logic signed [T_W-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
    return p[61:30];
  endfunction

endpackage

/* src/scp_if.sv */
// Valid/ready channel interfaces for angles and for sine/cosine results.
interface scp_angle_if;
  logic                               valid;
  logic                               ready;
  logic signed [scp_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface scp_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [scp_pkg::OUT_W-1:0] sine;
  logic signed [scp_pkg::OUT_W-1:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

/* src/scp_front.sv */
// Front end: accepts angles, finds the quarter-turn count and the reduced angle.
module scp_front #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  scp_angle_if.sink           in_ch,
  input  scp_pkg::scp_qstat_t qstat,
  output scp_pkg::scp_fstat_t fstat,
  output scp_pkg::scp_red_t   red
);

  localparam int QS = ANGLE_FRAC_BITS + 32;
  localparam int XS = 40 - ANGLE_FRAC_BITS;
  localparam logic signed [56:0] Q_HALF = 57'sd1 <<< (QS - 1);

  logic                               v1_r, v2_r, v3_r;
  logic signed [scp_pkg::ANGLE_W-1:0] a1_r, a2_r;
  logic signed [56:0]                 prod1_r;
  logic signed [scp_pkg::Q_W-1:0]     q2_r;
  logic signed [57:0]                 qc3_r, x3_r;
  logic [1:0]                         quad3_r;

  logic                               accept;
  logic [1:0]                         busy;
  logic signed [56:0]                 prod;
  logic signed [56:0]                 qfull;
  logic signed [57:0]                 t40;
  logic signed [57:0]                 t_full;

  // Every item in flight here is guaranteed a queue slot before it is taken.
  assign busy = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);
  assign in_ch.ready = ({1'b0, qstat.count} + 5'(busy)) < 5'(scp_pkg::QDEPTH);
  assign accept = in_ch.valid && in_ch.ready;

  assign prod  = 57'(in_ch.angle) * scp_pkg::TWO_OVER_PI_Q32;
  assign qfull = (prod1_r + Q_HALF) >>> QS;

  assign t40    = x3_r - qc3_r;
  assign t_full = (t40 + 58'sd512) >>> 10;

  assign fstat.push = v3_r;
  assign fstat.busy = busy;
  assign red.t      = t_full[scp_pkg::T_W-1:0];
  assign red.quad   = quad3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r    <= in_ch.angle;
    prod1_r <= prod;
    a2_r    <= a1_r;
    q2_r    <= qfull[scp_pkg::Q_W-1:0];
    qc3_r   <= 58'(q2_r) * scp_pkg::PIO2_Q40;
    x3_r    <= 58'(a2_r) <<< XS;
    quad3_r <= q2_r[1:0];
  end

endmodule

/* src/scp_queue.sv */
// Short first-in first-out queue of reduced angles between front end and evaluator.
module scp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scp_pkg::scp_red_t   din,
  input  logic                pop,
  output scp_pkg::scp_red_t   dout,
  output scp_pkg::scp_qstat_t qstat
);

  scp_pkg::scp_red_t                mem_r [scp_pkg::QDEPTH];
  logic [scp_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [scp_pkg::QCNT_W-1:0]       count_r;

  assign dout        = mem_r[rd_ptr_r];
  assign qstat.empty = (count_r == '0);
  assign qstat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* src/scp_back.sv */
// Evaluator: both minimax polynomials by Horner's rule, quadrant selection and output register.
module scp_back #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scp_pkg::scp_red_t   head,
  input  logic                empty,
  output logic                pop,
  scp_result_if.source        out_ch
);

  localparam int SH     = 30 - OUT_FRAC_BITS;
  localparam int HALF_S = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [33:0] HALF = (SH > 0) ? (34'sd1 <<< HALF_S) : 34'sd0;
  localparam logic signed [33:0] LIM  = 34'sd1 <<< OUT_FRAC_BITS;

  logic                             en;
  logic                             v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic signed [scp_pkg::T_W-1:0]   t1_r, t2_r, t3_r, t4_r;
  logic signed [scp_pkg::T_W-1:0]   sq1_r, sq2_r, sq3_r;
  logic [1:0]                       qd1_r, qd2_r, qd3_r, qd4_r, qd5_r;
  logic signed [scp_pkg::T_W-1:0]   ps2_r, ps3_r, ps4_r, ps5_r;
  logic signed [scp_pkg::T_W-1:0]   pc2_r, pc3_r, pc4_r, pc5_r;
  logic [scp_pkg::OUT_W-1:0]        sine_r, cosine_r;

  // Negate on request, round to the output format and clamp to plus or minus one.
  function automatic logic [scp_pkg::OUT_W-1:0] finish(input logic signed [scp_pkg::T_W-1:0] r,
                                                       input logic neg);
    logic signed [33:0] e;
    logic signed [33:0] rr;
    e = 34'(r);
    if (neg) begin
      e = -e;
    end
    rr = (e + HALF) >>> SH;
    if (rr > LIM) begin
      rr = LIM;
    end
    if (rr < -LIM) begin
      rr = -LIM;
    end
    return rr[scp_pkg::OUT_W-1:0];
  endfunction

  // The whole evaluator advances together unless a result is waiting to be taken.
  assign en  = !out_v_r || out_ch.ready;
  assign pop = en && !empty;

  assign out_ch.valid  = out_v_r;
  assign out_ch.sine   = sine_r;
  assign out_ch.cosine = cosine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= !empty;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      out_v_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= head.t;
      qd1_r <= head.quad;
      sq1_r <= scp_pkg::mul_q30(head.t, head.t);

      t2_r  <= t1_r;
      qd2_r <= qd1_r;
      sq2_r <= sq1_r;
      ps2_r <= scp_pkg::mul_q30(scp_pkg::SIN_K3, sq1_r) + scp_pkg::SIN_K2;
      pc2_r <= scp_pkg::mul_q30(scp_pkg::COS_K3, sq1_r) + scp_pkg::COS_K2;

      t3_r  <= t2_r;
      qd3_r <= qd2_r;
      sq3_r <= sq2_r;
      ps3_r <= scp_pkg::mul_q30(ps2_r, sq2_r) + scp_pkg::SIN_K1;
      pc3_r <= scp_pkg::mul_q30(pc2_r, sq2_r) + scp_pkg::COS_K1;

      t4_r  <= t3_r;
      qd4_r <= qd3_r;
      ps4_r <= scp_pkg::mul_q30(ps3_r, sq3_r) + scp_pkg::SIN_K0;
      pc4_r <= scp_pkg::mul_q30(pc3_r, sq3_r) + scp_pkg::COS_K0;

      qd5_r <= qd4_r;
      ps5_r <= scp_pkg::mul_q30(ps4_r, t4_r);
      pc5_r <= pc4_r;

      // Cosine takes the quarter count plus one: bit 0 flips, bit 1 toggles on a carry.
      sine_r   <= finish(qd5_r[0] ? pc5_r : ps5_r, qd5_r[1]);
      cosine_r <= finish(qd5_r[0] ? ps5_r : pc5_r, qd5_r[1] ^ qd5_r[0]);
    end
  end

endmodule

/* src/sine_cosine_polynomial.sv */
// Top level of the fixed-point sine and cosine unit: front end, queue and evaluator.
//
// Angles (signed Q8.16 radians by default) arrive on in_ch and leave as a sine and
// cosine pair on out_ch, both valid/ready channels; a transaction completes at a
// rising edge with valid and ready high. Each angle gives exactly one result pair.
// The unit takes one angle per cycle while in_ch.ready is high. An accepted angle
// passes three front-end stages (scaling by 2/pi, quarter rounding, reduction by
// pi/2), a write into the queue, then five evaluator stages of 32x32 multiplies,
// with the sine and cosine series side by side, and the output register.
// A queue of eight reduced angles sits between front end and evaluator. When out_ch
// stalls, the evaluator and its output register hold; the front end keeps taking
// angles until the queue and the front-end stages together hold eight items, then
// in_ch.ready drops. Reset (rst_n low, synchronous) empties the queue and clears
// every valid flag; no results are lost or duplicated across a stall.
module sine_cosine_polynomial #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  scp_angle_if.sink    in_ch,
  scp_result_if.source out_ch
);

  scp_pkg::scp_fstat_t fstat;
  scp_pkg::scp_qstat_t qstat;
  scp_pkg::scp_red_t   red;
  scp_pkg::scp_red_t   head;
  logic                pop;

  scp_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .qstat (qstat),
    .fstat (fstat),
    .red   (red)
  );

  scp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fstat.push),
    .din   (red),
    .pop   (pop),
    .dout  (head),
    .qstat (qstat)
  );

  scp_back #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (qstat.empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

  localparam int LIM_CHK = (OUT_FRAC_BITS > 16) ? 0 : (1 << OUT_FRAC_BITS);

  // The front end only ever writes into a queue that still has a free slot.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.push |-> (qstat.count < scp_pkg::QCNT_W'(scp_pkg::QDEPTH)))
    else $error("reduced angle written into a full queue");

  // Items held in the queue and the front-end stages never exceed the queue depth.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, qstat.count} + 5'(fstat.busy)) <= 5'(scp_pkg::QDEPTH)))
    else $error("front end holds more items than the queue can take");

  // Saturated results stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (OUT_FRAC_BITS > 16) ||
                     ((int'(out_ch.sine) >= -LIM_CHK) && (int'(out_ch.sine) <= LIM_CHK) &&
                      (int'(out_ch.cosine) >= -LIM_CHK) && (int'(out_ch.cosine) <= LIM_CHK)))
    else $error("result outside plus or minus one");

endmodule
